// ===== rtl/gcs_pkg.sv =====
// ----------------------------------------------------------------------------
// gcs_pkg - shared definitions for the glyph column stream generator
// Request and byte payload types, command codes, controller constants
// and the 5x8 font table.
// ----------------------------------------------------------------------------
package gcs_pkg;

  localparam int DIGIT_COUNT_DEF = 6;
  localparam int GLYPH_WIDTH     = 5;
  localparam int COL_W           = $clog2(GLYPH_WIDTH + 1);
  localparam int FONT_ROWS       = 95;
  localparam int ROW_W           = $clog2(FONT_ROWS);

  localparam logic [1:0] CMD_CHAR = 2'd0;
  localparam logic [1:0] CMD_NUM  = 2'd1;
  localparam logic [1:0] CMD_POS  = 2'd2;

  localparam logic [7:0] FIRST_CODE = 8'd32;
  localparam logic [7:0] LAST_CODE  = 8'd126;
  localparam logic [7:0] ROW_CMD    = 8'h40;
  localparam logic [7:0] COL_CMD    = 8'h80;
  localparam logic [7:0] ZERO_CHAR  = 8'h30;
  localparam logic [31:0] RECIP10   = 32'hCCCC_CCCD;  // ceil(2^35 / 10)

  typedef struct packed {
    logic [1:0]         command;
    logic [7:0]         char_code;
    logic signed [31:0] value;
    logic [6:0]         col_x;
    logic [2:0]         row_y;
  } req_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_data;
    logic       last;
  } byte_t;

  localparam logic [7:0] FONT [FONT_ROWS][GLYPH_WIDTH] = '{
    '{8'h00,8'h00,8'h00,8'h00,8'h00}, '{8'h00,8'h00,8'h2f,8'h00,8'h00},
    '{8'h00,8'h07,8'h00,8'h07,8'h00}, '{8'h14,8'h7f,8'h14,8'h7f,8'h14},
    '{8'h24,8'h2a,8'h7f,8'h2a,8'h12}, '{8'h62,8'h64,8'h08,8'h13,8'h23},
    '{8'h36,8'h49,8'h55,8'h22,8'h50}, '{8'h00,8'h05,8'h03,8'h00,8'h00},
    '{8'h00,8'h1c,8'h22,8'h41,8'h00}, '{8'h00,8'h41,8'h22,8'h1c,8'h00},
    '{8'h14,8'h08,8'h3e,8'h08,8'h14}, '{8'h08,8'h08,8'h3e,8'h08,8'h08},
    '{8'h00,8'h00,8'ha0,8'h60,8'h00}, '{8'h08,8'h08,8'h08,8'h08,8'h08},
    '{8'h00,8'h60,8'h60,8'h00,8'h00}, '{8'h20,8'h10,8'h08,8'h04,8'h02},
    '{8'h3e,8'h51,8'h49,8'h45,8'h3e}, '{8'h00,8'h42,8'h7f,8'h40,8'h00},
    '{8'h42,8'h61,8'h51,8'h49,8'h46}, '{8'h21,8'h41,8'h45,8'h4b,8'h31},
    '{8'h18,8'h14,8'h12,8'h7f,8'h10}, '{8'h27,8'h45,8'h45,8'h45,8'h39},
    '{8'h3c,8'h4a,8'h49,8'h49,8'h30}, '{8'h01,8'h71,8'h09,8'h05,8'h03},
    '{8'h36,8'h49,8'h49,8'h49,8'h36}, '{8'h06,8'h49,8'h49,8'h29,8'h1e},
    '{8'h00,8'h36,8'h36,8'h00,8'h00}, '{8'h00,8'h56,8'h36,8'h00,8'h00},
    '{8'h08,8'h14,8'h22,8'h41,8'h00}, '{8'h14,8'h14,8'h14,8'h14,8'h14},
    '{8'h00,8'h41,8'h22,8'h14,8'h08}, '{8'h02,8'h01,8'h51,8'h09,8'h06},
    '{8'h32,8'h49,8'h59,8'h51,8'h3e}, '{8'h7c,8'h12,8'h11,8'h12,8'h7c},
    '{8'h7f,8'h49,8'h49,8'h49,8'h36}, '{8'h3e,8'h41,8'h41,8'h41,8'h22},
    '{8'h7f,8'h41,8'h41,8'h22,8'h1c}, '{8'h7f,8'h49,8'h49,8'h49,8'h41},
    '{8'h7f,8'h09,8'h09,8'h09,8'h01}, '{8'h3e,8'h41,8'h49,8'h49,8'h7a},
    '{8'h7f,8'h08,8'h08,8'h08,8'h7f}, '{8'h00,8'h41,8'h7f,8'h41,8'h00},
    '{8'h20,8'h40,8'h41,8'h3f,8'h01}, '{8'h7f,8'h08,8'h14,8'h22,8'h41},
    '{8'h7f,8'h40,8'h40,8'h40,8'h40}, '{8'h7f,8'h02,8'h0c,8'h02,8'h7f},
    '{8'h7f,8'h04,8'h08,8'h10,8'h7f}, '{8'h3e,8'h41,8'h41,8'h41,8'h3e},
    '{8'h7f,8'h09,8'h09,8'h09,8'h06}, '{8'h3e,8'h41,8'h51,8'h21,8'h5e},
    '{8'h7f,8'h09,8'h19,8'h29,8'h46}, '{8'h46,8'h49,8'h49,8'h49,8'h31},
    '{8'h01,8'h01,8'h7f,8'h01,8'h01}, '{8'h3f,8'h40,8'h40,8'h40,8'h3f},
    '{8'h1f,8'h20,8'h40,8'h20,8'h1f}, '{8'h3f,8'h40,8'h38,8'h40,8'h3f},
    '{8'h63,8'h14,8'h08,8'h14,8'h63}, '{8'h07,8'h08,8'h70,8'h08,8'h07},
    '{8'h61,8'h51,8'h49,8'h45,8'h43}, '{8'h00,8'h7f,8'h41,8'h41,8'h00},
    '{8'h55,8'h2a,8'h55,8'h2a,8'h55}, '{8'h00,8'h41,8'h41,8'h7f,8'h00},
    '{8'h04,8'h02,8'h01,8'h02,8'h04}, '{8'h40,8'h40,8'h40,8'h40,8'h40},
    '{8'h00,8'h01,8'h02,8'h04,8'h00}, '{8'h20,8'h54,8'h54,8'h54,8'h78},
    '{8'h7f,8'h48,8'h44,8'h44,8'h38}, '{8'h38,8'h44,8'h44,8'h44,8'h20},
    '{8'h38,8'h44,8'h44,8'h48,8'h7f}, '{8'h38,8'h54,8'h54,8'h54,8'h18},
    '{8'h08,8'h7e,8'h09,8'h01,8'h02}, '{8'h18,8'ha4,8'ha4,8'ha4,8'h7c},
    '{8'h7f,8'h08,8'h04,8'h04,8'h78}, '{8'h00,8'h44,8'h7d,8'h40,8'h00},
    '{8'h40,8'h80,8'h84,8'h7d,8'h00}, '{8'h7f,8'h10,8'h28,8'h44,8'h00},
    '{8'h00,8'h41,8'h7f,8'h40,8'h00}, '{8'h7c,8'h04,8'h18,8'h04,8'h78},
    '{8'h7c,8'h08,8'h04,8'h04,8'h78}, '{8'h38,8'h44,8'h44,8'h44,8'h38},
    '{8'hfc,8'h24,8'h24,8'h24,8'h18}, '{8'h18,8'h24,8'h24,8'h18,8'hfc},
    '{8'h7c,8'h08,8'h04,8'h04,8'h08}, '{8'h48,8'h54,8'h54,8'h54,8'h20},
    '{8'h04,8'h3f,8'h44,8'h40,8'h20}, '{8'h3c,8'h40,8'h40,8'h20,8'h7c},
    '{8'h1c,8'h20,8'h40,8'h20,8'h1c}, '{8'h3c,8'h40,8'h30,8'h40,8'h3c},
    '{8'h44,8'h28,8'h10,8'h28,8'h44}, '{8'h1c,8'ha0,8'ha0,8'ha0,8'h7c},
    '{8'h44,8'h64,8'h54,8'h4c,8'h44}, '{8'h00,8'h08,8'h36,8'h41,8'h00},
    '{8'h00,8'h00,8'h7f,8'h00,8'h00}, '{8'h00,8'h41,8'h36,8'h08,8'h00},
    '{8'h08,8'h10,8'h08,8'h04,8'h08}
  };

  // Font column for a code; codes outside the printable range render as space,
  // and the column after the glyph is blank.
  function automatic logic [7:0] font_col(input logic [7:0] code,
                                          input logic [COL_W-1:0] col);
    logic [ROW_W-1:0] row;
    logic [7:0]       res;
    row = '0;
    res = 8'h00;
    if (code >= FIRST_CODE && code <= LAST_CODE) begin
      row = ROW_W'(code - FIRST_CODE);
    end
    if (col < COL_W'(GLYPH_WIDTH)) begin
      res = FONT[row][col[$clog2(GLYPH_WIDTH)-1:0]];
    end
    return res;
  endfunction

endpackage

// ===== rtl/gcs_stream_if.sv =====
// ----------------------------------------------------------------------------
// gcs_stream_if - valid/ready stream channel
// Carries one payload per transaction; source drives valid and payload,
// sink drives ready.
// ----------------------------------------------------------------------------
interface gcs_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/glyph_column_stream_generator_unit.sv =====
// ----------------------------------------------------------------------------
// glyph_column_stream_generator_unit - display request to controller bytes
// Expands character, number and set-position requests into command and
// font column bytes for a 5x8 character display controller.
// ----------------------------------------------------------------------------
//  channel  dir  payload          transaction
//  req      in   gcs_pkg::req_t   one display request
//  dout     out  gcs_pkg::byte_t  one controller byte, last marks request end
//
// One output byte per cycle when dout is not stalled and, for a number, the
// digit conversion has finished: a character gives 6 bytes, set-position 2,
// a number 2 + 6*DIGIT_COUNT, and its digit bytes wait on the digit converter
// (one reciprocal multiply per digit into the digit RAM). The first byte of
// a request passes the state register, the s1 token register and the dout
// register. Reset is synchronous and only clears control state.
// A stalled dout freezes the byte pipeline; an idle sequencer still takes a
// request, and the next request is taken in the cycle the last byte issues.
// ----------------------------------------------------------------------------
module glyph_column_stream_generator_unit #(
  parameter int DIGIT_COUNT = gcs_pkg::DIGIT_COUNT_DEF
) (
  input  logic         clk,
  input  logic         rst,
  gcs_stream_if.sink   req,
  gcs_stream_if.source dout
);
  import gcs_pkg::*;

  localparam int DIG_W = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;

  typedef enum logic [1:0] {S_IDLE, S_ROW, S_COL, S_GLYPH} state_t;

  typedef struct packed {
    logic             valid;
    logic             is_data;
    logic             last;
    logic             use_font;
    logic             from_digit;
    logic [COL_W-1:0] col;
    logic [7:0]       code;
    logic [7:0]       cmd_byte;
  } tok_t;

  state_t           state;
  logic [1:0]       cmd;
  logic [7:0]       code;
  logic [6:0]       col_x;
  logic [2:0]       row_y;
  logic [COL_W-1:0] col;
  logic [DIG_W-1:0] dig;
  tok_t             s1;

  // digit converter
  logic [31:0]      mag;
  logic             neg;
  logic [DIG_W-1:0] conv_cnt;
  logic             conv_done;
  logic [63:0]      prod;
  logic [31:0]      quo;
  logic [3:0]       rem;
  logic [7:0]       digit;
  logic [DIG_W-1:0] waddr;

  logic [7:0] dmem [DIGIT_COUNT];
  logic [7:0] dmem_q;

  logic advance;
  logic issue;
  logic req_acc;
  tok_t tok;

  always_comb begin
    prod  = 64'(mag) * 64'(RECIP10);
    quo   = {3'b000, prod[63:35]};
    rem   = 4'(mag - (quo << 3) - (quo << 1));
    digit = neg ? (ZERO_CHAR - {4'b0000, rem}) : (ZERO_CHAR + {4'b0000, rem});
    waddr = DIG_W'(DIGIT_COUNT - 1) - conv_cnt;
  end

  always_comb begin
    advance      = !dout.valid || dout.ready;
    issue        = 1'b0;
    tok          = '0;
    tok.code     = code;
    tok.col      = col;
    case (state)
      S_ROW: begin
        issue        = advance;
        tok.cmd_byte = ROW_CMD | {5'b00000, row_y};
      end
      S_COL: begin
        issue        = advance;
        tok.cmd_byte = COL_CMD | {1'b0, col_x};
        tok.last     = (cmd == CMD_POS);
      end
      S_GLYPH: begin
        // number digits are read MSB first, so wait for the whole conversion
        issue          = advance && (cmd == CMD_CHAR || conv_done);
        tok.is_data    = 1'b1;
        tok.use_font   = 1'b1;
        tok.from_digit = (cmd == CMD_NUM);
        tok.last       = (col == COL_W'(GLYPH_WIDTH)) &&
                         (cmd == CMD_CHAR || dig == DIG_W'(DIGIT_COUNT - 1));
      end
      default: begin
        issue = 1'b0;
      end
    endcase
    tok.valid = issue;
    req.ready = (state == S_IDLE) || (issue && tok.last);
    req_acc   = req.valid && req.ready;
  end

  always_ff @(posedge clk) begin
    if (!conv_done) begin
      dmem[waddr] <= digit;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      dmem_q <= dmem[dig];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      s1.valid   <= 1'b0;
      dout.valid <= 1'b0;
      conv_done  <= 1'b1;
    end else begin
      // a request taken with the last byte replaces the return to idle
      if (req_acc) begin
        cmd      <= req.payload.command;
        code     <= req.payload.char_code;
        col_x    <= req.payload.col_x;
        row_y    <= req.payload.row_y;
        col      <= '0;
        dig      <= '0;
        neg      <= req.payload.value[31];
        mag      <= req.payload.value[31] ? (~req.payload.value + 32'd1)
                                          : req.payload.value;
        conv_cnt <= '0;
        conv_done <= (req.payload.command != CMD_NUM);
        case (req.payload.command)
          CMD_CHAR: state <= S_GLYPH;
          CMD_NUM:  state <= S_ROW;
          CMD_POS:  state <= S_ROW;
          default:  state <= S_IDLE;  // unused code: dropped
        endcase
      end else begin
        if (issue) begin
          case (state)
            S_ROW:   state <= S_COL;
            S_COL:   state <= (cmd == CMD_POS) ? S_IDLE : S_GLYPH;
            S_GLYPH: begin
              if (tok.last) begin
                state <= S_IDLE;
              end else if (col == COL_W'(GLYPH_WIDTH)) begin
                col <= '0;
                dig <= dig + DIG_W'(1);
              end else begin
                col <= col + COL_W'(1);
              end
            end
            default: state <= S_IDLE;
          endcase
        end

        if (!conv_done) begin
          mag      <= quo;
          conv_cnt <= conv_cnt + DIG_W'(1);
          if (conv_cnt == DIG_W'(DIGIT_COUNT - 1)) begin
            conv_done <= 1'b1;
          end
        end
      end

      if (advance) begin
        s1                   <= tok;
        dout.valid           <= s1.valid;
        dout.payload.is_data <= s1.is_data;
        dout.payload.last    <= s1.last;
        dout.payload.out_byte <= s1.use_font
                                 ? font_col(s1.from_digit ? dmem_q : s1.code, s1.col)
                                 : s1.cmd_byte;
      end
    end
  end

  a_digit_ready: assert property (@(posedge clk) disable iff (rst)
    (issue && state == S_GLYPH && cmd == CMD_NUM) |-> conv_done)
    else $error("number glyph issued before digit conversion finished");

  a_idle_after_last: assert property (@(posedge clk) disable iff (rst)
    (issue && tok.last && !req_acc) |=> (state == S_IDLE))
    else $error("sequencer busy after last byte of request");

  a_cmd_byte_code: assert property (@(posedge clk) disable iff (rst)
    (dout.valid && !dout.payload.is_data) |->
      (dout.payload.out_byte[7] || dout.payload.out_byte[6]))
    else $error("controller command byte without position opcode");

  a_conv_bound: assert property (@(posedge clk) disable iff (rst)
    !conv_done |-> (conv_cnt <= DIG_W'(DIGIT_COUNT - 1)))
    else $error("digit counter ran past digit count");

endmodule
